### hdl/weighted_group_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted group scheduler
// Shared property wrappers used by the scheduler's checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_GROUP_SCHEDULER_CORE_ASSERT_SVH
`define WEIGHTED_GROUP_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WGS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("weighted group scheduler: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WGS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("weighted group scheduler: next-cycle check failed");

`endif

### hdl/wgs_pkg.sv
// ----------------------------------------------------------------------------
// wgs_pkg
// Types and constants shared by the weighted group scheduler files.
// ----------------------------------------------------------------------------
package wgs_pkg;

	localparam int DEF_MAX_GROUPS = 16;
	localparam int CODE_W         = 8;
	localparam int WGT_W          = 8;
	localparam int OUT_TOTAL_W    = 12;

	typedef enum logic [2:0] {
		ST_SELECTED = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_UPDATED  = 3'd2,
		ST_ADDED    = 3'd3,
		ST_REMOVED  = 3'd4,
		ST_MISS     = 3'd5,
		ST_FULL     = 3'd6
	} status_t;

	// Control part of the scan token that walks down the cell chain.
	typedef struct packed {
		logic vld;   // token present at this cell
		logic func;  // 0 set, 1 next
		logic hit;   // code found (set) or entry chosen (next) upstream
	} tok_ctl_t;

endpackage

### hdl/wgs_cell.sv
// ----------------------------------------------------------------------------
// wgs_cell
// One table entry of the scheduler plus one stage of the scan token.
// ----------------------------------------------------------------------------
module wgs_cell #(
	parameter int MAX_GROUPS = wgs_pkg::DEF_MAX_GROUPS,
	parameter int IDX        = 0,
	parameter int TW         = 13,
	localparam int CW        = $clog2(MAX_GROUPS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [CW-1:0]                cnt,
	input  wgs_pkg::tok_ctl_t            ctl_in,
	input  logic [wgs_pkg::CODE_W-1:0]   code_in,
	input  logic [wgs_pkg::WGT_W-1:0]    wgt_in,
	input  logic [wgs_pkg::WGT_W-1:0]    old_in,
	input  logic [TW-1:0]                sum_in,
	input  logic [TW-1:0]                ctr_in,
	output wgs_pkg::tok_ctl_t            ctl_out,
	output logic [wgs_pkg::CODE_W-1:0]   code_out,
	output logic [wgs_pkg::WGT_W-1:0]    wgt_out,
	output logic [wgs_pkg::WGT_W-1:0]    old_out,
	output logic [TW-1:0]                sum_out,
	output logic [TW-1:0]                ctr_out,
	input  logic [wgs_pkg::CODE_W-1:0]   nb_code,
	input  logic [wgs_pkg::WGT_W-1:0]    nb_wgt,
	output logic [wgs_pkg::CODE_W-1:0]   st_code,
	output logic [wgs_pkg::WGT_W-1:0]    st_wgt
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [wgs_pkg::CODE_W-1:0] code_q;
	logic [wgs_pkg::WGT_W-1:0]  wgt_q;
	wgs_pkg::tok_ctl_t          ctl_q;
	logic [wgs_pkg::CODE_W-1:0] tcode_q;
	logic [wgs_pkg::WGT_W-1:0]  twgt_q;
	logic [wgs_pkg::WGT_W-1:0]  told_q;
	logic [TW-1:0]              tsum_q;
	logic [TW-1:0]              tctr_q;

	wgs_pkg::tok_ctl_t          nxt_ctl;
	logic [wgs_pkg::CODE_W-1:0] nxt_code;
	logic [wgs_pkg::WGT_W-1:0]  nxt_old;
	logic [TW-1:0]              nxt_sum;
	logic [TW-1:0]              sum_here;
	logic                       live;
	logic                       match;
	logic                       ld_nb;
	logic                       ld_add;
	logic                       ld_upd;

	assign live     = (IDX_C < cnt);
	assign match    = live && !ctl_in.func && (code_q == code_in);
	assign sum_here = sum_in + TW'(wgt_q);

	always_comb begin
		nxt_ctl  = ctl_in;
		nxt_code = code_in;
		nxt_old  = old_in;
		nxt_sum  = sum_in;
		ld_nb    = 1'b0;
		ld_add   = 1'b0;
		ld_upd   = 1'b0;
		if (ctl_in.vld) begin
			if (!ctl_in.func) begin
				if (match) begin
					nxt_ctl.hit = 1'b1;
					nxt_old     = wgt_q;
				end
				if (wgt_in == '0) begin
					// Removal: this entry and every later live one pull from the right.
					ld_nb = live && (ctl_in.hit || match);
				end else begin
					ld_upd = match;
					ld_add = (IDX_C == cnt) && !ctl_in.hit;
				end
			end else if (live && !ctl_in.hit) begin
				nxt_sum = sum_here;
				if (ctr_in < sum_here) begin
					nxt_ctl.hit = 1'b1;
					nxt_code    = code_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_nb) begin
			code_q <= nb_code;
			wgt_q  <= nb_wgt;
		end else if (ld_add) begin
			code_q <= code_in;
			wgt_q  <= wgt_in;
		end else if (ld_upd) begin
			wgt_q  <= wgt_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= nxt_ctl;
		end
	end

	always_ff @(posedge clk) begin
		tcode_q <= nxt_code;
		twgt_q  <= wgt_in;
		told_q  <= nxt_old;
		tsum_q  <= nxt_sum;
		tctr_q  <= ctr_in;
	end

	assign ctl_out  = ctl_q;
	assign code_out = tcode_q;
	assign wgt_out  = twgt_q;
	assign old_out  = told_q;
	assign sum_out  = tsum_q;
	assign ctr_out  = tctr_q;
	assign st_code  = code_q;
	assign st_wgt   = wgt_q;

endmodule

### hdl/weighted_group_scheduler_core.sv
// ----------------------------------------------------------------------------
// weighted_group_scheduler_core
// Weighted round-robin choice among group codes, built as a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | start, busy           | func, group_code, weight
//  result   | done (one-cycle)      | status, chosen_code, weight_total
//
// Every item passes through the token register and then each cell in turn,
// ending in its done cycle. busy is high from the accepting edge to the edge
// that raises done, so the next item is taken at the edge that ends the done
// cycle at the earliest: a new item is not taken while one is in the chain.
// The result channel has no back-pressure.
// Reset clears the count, total, counter, busy, done and token valids, not the table.
//
// The table lives in the cells: cell i holds entry i. A set item finds,
// updates, appends or removes (by pulling each later entry one place left)
// as the token passes. A next item advances the counter at acceptance and
// the token accumulates the prefix sum, picking the first entry whose
// running sum exceeds the counter.
// ----------------------------------------------------------------------------
module weighted_group_scheduler_core #(
	parameter int MAX_GROUPS = wgs_pkg::DEF_MAX_GROUPS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [wgs_pkg::CODE_W-1:0]        group_code,
	input  logic [wgs_pkg::WGT_W-1:0]         weight,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [wgs_pkg::CODE_W-1:0]        chosen_code,
	output logic [wgs_pkg::OUT_TOTAL_W-1:0]   weight_total
);

	// Entry count width, and an internal sum width wide enough for the exact
	// total and never narrower than the reported field.
	localparam int CW   = $clog2(MAX_GROUPS + 1);
	localparam int SUMW = wgs_pkg::WGT_W + $clog2(MAX_GROUPS + 1);
	localparam int TW   = (SUMW > wgs_pkg::OUT_TOTAL_W) ? SUMW : wgs_pkg::OUT_TOTAL_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_GROUPS);

	// Architectural state.
	logic [CW-1:0]  count_q;
	logic [TW-1:0]  total_q;
	logic [TW-1:0]  ctr_q;
	logic           busy_q;

	// Result register.
	logic                       done_q;
	wgs_pkg::status_t           status_q;
	logic [wgs_pkg::CODE_W-1:0] chosen_q;
	logic [TW-1:0]              wtot_q;

	// Token chain: index 0 is the injection register, index MAX_GROUPS the tail.
	wgs_pkg::tok_ctl_t          ctl_w  [MAX_GROUPS+1];
	logic [wgs_pkg::CODE_W-1:0] code_w [MAX_GROUPS+1];
	logic [wgs_pkg::WGT_W-1:0]  wgt_w  [MAX_GROUPS+1];
	logic [wgs_pkg::WGT_W-1:0]  old_w  [MAX_GROUPS+1];
	logic [TW-1:0]              sum_w  [MAX_GROUPS+1];
	logic [TW-1:0]              ctr_w  [MAX_GROUPS+1];

	// Stored entries, exposed so each cell can pull from its right neighbor.
	logic [wgs_pkg::CODE_W-1:0] st_code [MAX_GROUPS+1];
	logic [wgs_pkg::WGT_W-1:0]  st_wgt  [MAX_GROUPS+1];

	wgs_pkg::tok_ctl_t          inj_ctl_q;
	logic [wgs_pkg::CODE_W-1:0] inj_code_q;
	logic [wgs_pkg::WGT_W-1:0]  inj_wgt_q;
	logic [TW-1:0]              inj_ctr_q;

	logic           accept;
	logic           table_empty;
	logic [TW-1:0]  ctr_inc;
	logic [TW-1:0]  ctr_adv;

	wgs_pkg::status_t res_status;
	logic [wgs_pkg::CODE_W-1:0] res_chosen;
	logic [TW-1:0]  res_total;
	logic [CW-1:0]  res_count;

	assign accept      = start && !busy_q;
	assign table_empty = (count_q == '0) || (total_q == '0);
	assign ctr_inc     = ctr_q + TW'(1);
	assign ctr_adv     = (ctr_inc >= total_q) ? '0 : ctr_inc;

	// Token injection: for next items the counter already advanced (non-empty
	// table) and the code zeroed, so the chosen code can ride in the same field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_ctl_q <= '0;
		end else begin
			inj_ctl_q.vld  <= accept;
			inj_ctl_q.func <= func;
			inj_ctl_q.hit  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inj_code_q <= func ? '0 : group_code;
			inj_wgt_q  <= weight;
			inj_ctr_q  <= (func && !table_empty) ? ctr_adv : ctr_q;
		end
	end

	assign ctl_w[0]  = inj_ctl_q;
	assign code_w[0] = inj_code_q;
	assign wgt_w[0]  = inj_wgt_q;
	assign old_w[0]  = '0;
	assign sum_w[0]  = '0;
	assign ctr_w[0]  = inj_ctr_q;

	// Beyond the last cell there is nothing to pull; a removal leaves the
	// last place outside the new count, so its contents do not matter.
	assign st_code[MAX_GROUPS] = '0;
	assign st_wgt[MAX_GROUPS]  = '0;

	for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
		wgs_cell #(
			.MAX_GROUPS (MAX_GROUPS),
			.IDX        (i),
			.TW         (TW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cnt      (count_q),
			.ctl_in   (ctl_w[i]),
			.code_in  (code_w[i]),
			.wgt_in   (wgt_w[i]),
			.old_in   (old_w[i]),
			.sum_in   (sum_w[i]),
			.ctr_in   (ctr_w[i]),
			.ctl_out  (ctl_w[i+1]),
			.code_out (code_w[i+1]),
			.wgt_out  (wgt_w[i+1]),
			.old_out  (old_w[i+1]),
			.sum_out  (sum_w[i+1]),
			.ctr_out  (ctr_w[i+1]),
			.nb_code  (st_code[i+1]),
			.nb_wgt   (st_wgt[i+1]),
			.st_code  (st_code[i]),
			.st_wgt   (st_wgt[i])
		);
	end

	// Result formation from the token at the tail of the chain. The table
	// count and total are stable for the whole scan, so the outcome follows
	// from the token's hit flag and the old weight it picked up.
	always_comb begin
		res_status = wgs_pkg::ST_EMPTY;
		res_chosen = '0;
		res_total  = total_q;
		res_count  = count_q;
		if (ctl_w[MAX_GROUPS].func) begin
			if (!table_empty && ctl_w[MAX_GROUPS].hit) begin
				res_status = wgs_pkg::ST_SELECTED;
				res_chosen = code_w[MAX_GROUPS];
			end
		end else if (wgt_w[MAX_GROUPS] == '0) begin
			if (ctl_w[MAX_GROUPS].hit) begin
				res_status = wgs_pkg::ST_REMOVED;
				res_total  = total_q - TW'(old_w[MAX_GROUPS]);
				res_count  = count_q - CW'(1);
			end else begin
				res_status = wgs_pkg::ST_MISS;
			end
		end else if (ctl_w[MAX_GROUPS].hit) begin
			res_status = wgs_pkg::ST_UPDATED;
			res_total  = total_q - TW'(old_w[MAX_GROUPS]) + TW'(wgt_w[MAX_GROUPS]);
		end else if (count_q >= MAX_C) begin
			res_status = wgs_pkg::ST_FULL;
		end else begin
			res_status = wgs_pkg::ST_ADDED;
			res_total  = total_q + TW'(wgt_w[MAX_GROUPS]);
			res_count  = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			ctr_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl_w[MAX_GROUPS].vld;
			if (accept) begin
				busy_q <= 1'b1;
				if (func && !table_empty) begin
					ctr_q <= ctr_adv;
				end
			end else if (ctl_w[MAX_GROUPS].vld) begin
				busy_q  <= 1'b0;
				count_q <= res_count;
				total_q <= res_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_w[MAX_GROUPS].vld) begin
			status_q <= res_status;
			chosen_q <= res_chosen;
			wtot_q   <= res_total;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign status       = status_q;
	assign chosen_code  = chosen_q;
	assign weight_total = wtot_q[wgs_pkg::OUT_TOTAL_W-1:0];

endmodule

### hdl/wgs_checker.sv
// ----------------------------------------------------------------------------
// wgs_checker
// Port-level checks of the weighted group scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_group_scheduler_core_assert.svh"

module wgs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [2:0]                        status,
	input logic [wgs_pkg::CODE_W-1:0]        chosen_code
);

	// An accepted item keeps the block busy until its result.
	`WGS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// The result cycle is the cycle the block frees up.
	`WGS_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)

	// One result per item.
	`WGS_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

	// Only a selection carries a code.
	`WGS_ASSERT_NOW(a_code_zero, clk, arst_n,
		done && (status != wgs_pkg::ST_SELECTED), chosen_code == '0)

endmodule

bind weighted_group_scheduler_core wgs_checker u_wgs_checker (.*);

### bench/weighted_group_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_group_scheduler_core_tb
// Self-checking bench for the weighted group scheduler. A queue of items
// feeds a clocked driver, and a behavioral table model predicts each result.
// A clocked monitor checks every done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module weighted_group_scheduler_core_tb;

	localparam int GROUPS          = wgs_pkg::DEF_MAX_GROUPS;
	localparam int CODE_W          = wgs_pkg::CODE_W;
	localparam int WGT_W           = wgs_pkg::WGT_W;
	localparam int OUT_TOTAL_W     = wgs_pkg::OUT_TOTAL_W;
	localparam int CODE_POOL       = 24;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 340;
	localparam int RUN_LIMIT_NS    = 5_000_000;

	localparam logic FUNC_SET  = 1'b0;
	localparam logic FUNC_NEXT = 1'b1;

	typedef struct packed {
		logic              func;
		logic [CODE_W-1:0] code;
		logic [WGT_W-1:0]  wgt;
	} sched_item_t;

	typedef struct packed {
		wgs_pkg::status_t       status;
		logic [CODE_W-1:0]      code;
		logic [OUT_TOTAL_W-1:0] total;
	} sched_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   start      = 1'b0;
	logic                   func       = FUNC_SET;
	logic [CODE_W-1:0]      group_code = '0;
	logic [WGT_W-1:0]       weight     = '0;
	logic                   busy;
	logic                   done;
	logic [2:0]             status;
	logic [CODE_W-1:0]      chosen_code;
	logic [OUT_TOTAL_W-1:0] weight_total;

	weighted_group_scheduler_core #(
		.MAX_GROUPS(GROUPS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.group_code  (group_code),
		.weight      (weight),
		.done        (done),
		.status      (status),
		.chosen_code (chosen_code),
		.weight_total(weight_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queues between the stimulus, the driver and the monitor.
	sched_item_t   pending_items[$];
	sched_result_t expected_results[$];
	int            n_queued   = 0;
	int            n_accepted = 0;
	int            n_results  = 0;
	int            err_count  = 0;
	int            sender_idle_pct = 0;

	// Model of the table: entries in order, weight sum and rotation counter.
	logic [CODE_W-1:0] tbl_code[GROUPS];
	logic [WGT_W-1:0]  tbl_wgt[GROUPS];
	int                tbl_count = 0;
	int                wsum      = 0;
	int                sched_pos = 0;

	// Applies one item to the table model and returns the result it gives.
	function automatic sched_result_t schedule_outcome(sched_item_t it);
		sched_result_t r;
		int            pos;
		int            run_sum;
		r.status = wgs_pkg::ST_EMPTY;
		r.code   = '0;
		if (it.func == FUNC_SET) begin
			pos = tbl_count;
			for (int i = 0; i < tbl_count; i++) begin
				if (pos == tbl_count && tbl_code[i] == it.code)
					pos = i;
			end
			if (it.wgt == '0) begin
				if (pos == tbl_count) begin
					r.status = wgs_pkg::ST_MISS;
				end else begin
					// Removal closes the gap by pulling later entries left.
					wsum = wsum - int'(tbl_wgt[pos]);
					for (int j = pos; j < tbl_count - 1; j++) begin
						tbl_code[j] = tbl_code[j + 1];
						tbl_wgt[j]  = tbl_wgt[j + 1];
					end
					tbl_count--;
					r.status = wgs_pkg::ST_REMOVED;
				end
			end else if (pos < tbl_count) begin
				wsum        = wsum - int'(tbl_wgt[pos]) + int'(it.wgt);
				tbl_wgt[pos] = it.wgt;
				r.status    = wgs_pkg::ST_UPDATED;
			end else if (tbl_count >= GROUPS) begin
				r.status = wgs_pkg::ST_FULL;
			end else begin
				tbl_code[tbl_count] = it.code;
				tbl_wgt[tbl_count]  = it.wgt;
				tbl_count++;
				wsum     = wsum + int'(it.wgt);
				r.status = wgs_pkg::ST_ADDED;
			end
		end else if (tbl_count != 0 && wsum != 0) begin
			// A counter left stale by a weight change wraps here.
			sched_pos++;
			if (sched_pos >= wsum)
				sched_pos = 0;
			run_sum = 0;
			for (int i = 0; i < tbl_count; i++) begin
				run_sum = run_sum + int'(tbl_wgt[i]);
				if (r.status == wgs_pkg::ST_EMPTY && sched_pos < run_sum) begin
					r.status = wgs_pkg::ST_SELECTED;
					r.code   = tbl_code[i];
				end
			end
		end
		r.total = OUT_TOTAL_W'(wsum);
		return r;
	endfunction

	task automatic queue_item(logic f, logic [CODE_W-1:0] c, logic [WGT_W-1:0] w);
		sched_item_t it;
		it.func = f;
		it.code = c;
		it.wgt  = w;
		pending_items.push_back(it);
		n_queued++;
	endtask

	// Driver: an item is taken at an edge where start is high and busy low.
	// The port values are held while busy; a new item is presented only
	// once the current one has gone, and only if the sender is not idling.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		sched_item_t it;
		if (!arst_n) begin
			start      <= 1'b0;
			func       <= FUNC_SET;
			group_code <= '0;
			weight     <= '0;
		end else begin
			if (start && !busy) begin
				it = {func, group_code, weight};
				expected_results.push_back(schedule_outcome(it));
				n_accepted++;
			end
			if (!start || !busy) begin
				if (pending_items.size() > 0 &&
				    $urandom_range(0, 99) >= sender_idle_pct) begin
					it = pending_items.pop_front();
					start      <= 1'b1;
					func       <= it.func;
					group_code <= it.code;
					weight     <= it.wgt;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done pulse is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		sched_result_t exp_r;
		if (arst_n && done) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d code %0d total %0d",
				         $time, status, chosen_code, weight_total);
				err_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d got %0d",
					         $time, exp_r.status, status);
					err_count++;
				end
				if (chosen_code !== exp_r.code) begin
					$display("%0t: chosen_code expected %0d got %0d",
					         $time, exp_r.code, chosen_code);
					err_count++;
				end
				if (weight_total !== exp_r.total) begin
					$display("%0t: weight_total expected %0d got %0d",
					         $time, exp_r.total, weight_total);
					err_count++;
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int                phase_idle[PHASES];
		logic [CODE_W-1:0] code_pool[CODE_POOL];
		logic [CODE_W-1:0] fill_codes[GROUPS];
		sched_item_t       it;
		int                roll;
		phase_idle = '{0, 88, 32, 0, 88};
		fill_codes = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
		               8'h40, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33, 8'hCC};

		// Directed part: next and remove on an empty table, a full table at
		// the largest weight sum, a dropped insert, an update, and removal at
		// both ends of the table.
		queue_item(FUNC_NEXT, 8'hFF, 8'hFF);
		queue_item(FUNC_SET, 8'h07, 8'h00);
		foreach (fill_codes[k])
			queue_item(FUNC_SET, fill_codes[k], 8'hFF);
		queue_item(FUNC_SET, 8'h77, 8'h80);
		queue_item(FUNC_NEXT, 8'h00, 8'h00);
		queue_item(FUNC_SET, 8'hFF, 8'h01);
		queue_item(FUNC_SET, 8'h00, 8'h00);
		queue_item(FUNC_SET, 8'hCC, 8'h00);
		queue_item(FUNC_NEXT, 8'h5A, 8'hA5);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Random part: codes come mostly from a small pool so that updates,
		// removals and a full table happen often; small weights make the
		// counter wrap and go stale after weight changes.
		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct = phase_idle[p];
			foreach (code_pool[k])
				code_pool[k] = CODE_W'($urandom_range(0, 255));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll    = $urandom_range(0, 99);
				it.func = (roll < 45) ? FUNC_NEXT : FUNC_SET;
				if ($urandom_range(0, 9) == 0)
					it.code = CODE_W'($urandom);
				else
					it.code = code_pool[$urandom_range(0, CODE_POOL - 1)];
				roll = $urandom_range(0, 99);
				if (roll < 15)
					it.wgt = '0;
				else if (roll < 55)
					it.wgt = WGT_W'($urandom_range(1, 3));
				else
					it.wgt = WGT_W'($urandom_range(1, 255));
				queue_item(it.func, it.code, it.wgt);
			end
			wait (n_accepted == n_queued);
		end

		wait (n_results >= n_accepted);
		repeat (2 * GROUPS + 8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived",
			         $time, expected_results.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
